// ===== src/rbqs_pkg.sv =====
// ----------------------------------------------------------------------------
// rbqs_pkg
// Shared modes, total codes, sizes and the divider request and response types.
// ----------------------------------------------------------------------------
package rbqs_pkg;

	localparam int READ_LEN_BITS = 24;
	localparam int COUNT_BITS = 40;
	localparam int QUAL_BINS = 256;
	localparam int GC_BINS = 101;

	localparam logic [2:0] MODE_BASE = 3'd0;
	localparam logic [2:0] MODE_QBIN = 3'd1;
	localparam logic [2:0] MODE_GCBIN = 3'd2;
	localparam logic [2:0] MODE_MQBIN = 3'd3;
	localparam logic [2:0] MODE_TOTAL = 3'd4;

	localparam logic [7:0] TOT_A = 8'd0;
	localparam logic [7:0] TOT_C = 8'd1;
	localparam logic [7:0] TOT_G = 8'd2;
	localparam logic [7:0] TOT_TU = 8'd3;
	localparam logic [7:0] TOT_BASES = 8'd4;
	localparam logic [7:0] TOT_READS = 8'd5;

	localparam int DIV_BITS = 40;

	typedef struct packed {
		logic start;
		logic [DIV_BITS-1:0] num;
		logic [DIV_BITS-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DIV_BITS-1:0] quo;
	} div_rsp_t;

endpackage

// ===== src/rbqs_div.sv =====
// ----------------------------------------------------------------------------
// rbqs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rbqs_div
	import rbqs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CW = $clog2(DIV_BITS + 1);

	logic [DIV_BITS-1:0] num_q, den_q, quo_q;
	logic [DIV_BITS:0]   rem_q;
	logic [CW-1:0]       cnt_q;
	logic                busy_q, done_q;
	logic [DIV_BITS:0]   trial;

	assign trial = {rem_q[DIV_BITS-1:0], num_q[DIV_BITS-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(DIV_BITS);
				num_q <= req.num;
				den_q <= req.den;
				rem_q <= '0;
				quo_q <= '0;
			end else if (busy_q) begin
				num_q <= {num_q[DIV_BITS-2:0], 1'b0};
				if (!trial[DIV_BITS]) begin
					rem_q <= trial;
					quo_q <= {quo_q[DIV_BITS-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[DIV_BITS-1:0], num_q[DIV_BITS-1]};
					quo_q <= {quo_q[DIV_BITS-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;

endmodule

// ===== src/read_base_quality_stats_core.sv =====
// ----------------------------------------------------------------------------
// read_base_quality_stats_core
// Per-read base, GC and quality statistics with histogram queries.
// ----------------------------------------------------------------------------
// A base item that does not end its read takes a memory read and a write
// back. A query registers its result in ST_QUERY and raises it in ST_OUT.
// A read's last base runs two serial divisions (GC, then mean quality), a
// histogram read and write back, then its summary. A waiting result holds
// off the input. After reset a clearing pass zeroes the three histogram
// memories, one address per cycle, before any item is taken.
module read_base_quality_stats_core
	import rbqs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata: base_char[7:0], quality_char[15:8], bin_index[23:16]
	input  logic [23:0] s_tdata,
	// tuser: mode[2:0]
	input  logic [2:0]  s_tuser,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata: read_length[23:0], gc_percent[30:24], mean_quality[38:31],
	// count_value[78:39], quality_clamped[79]
	output logic [79:0] m_tdata,
	// tuser: result_kind
	output logic        m_tuser
);

	localparam int QW = $clog2(QUAL_BINS);
	localparam logic [COUNT_BITS-1:0] CMAX = '1;
	localparam logic [READ_LEN_BITS-1:0] LMAX = '1;
	localparam int SW = READ_LEN_BITS + 8;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_BASE, ST_QUERY, ST_DIV_GC, ST_DIV_MQ,
		ST_RD_HIST, ST_WB_HIST, ST_OUT
	} state_t;

	state_t state_q;

	logic [COUNT_BITS-1:0] qmem [QUAL_BINS];
	logic [COUNT_BITS-1:0] gmem [GC_BINS];
	logic [COUNT_BITS-1:0] mmem [QUAL_BINS];
	logic [COUNT_BITS-1:0] qrd_q, grd_q, mrd_q;
	logic [QW-1:0] qaddr, gaddr, maddr, qwa_q, clr_q;
	logic [6:0] gwa_q;
	logic qwe, gwe, mwe;
	logic [COUNT_BITS-1:0] qwd, gwd, mwd;

	logic [7:0] offset_q;
	logic [COUNT_BITS-1:0] cnt_a_q, cnt_c_q, cnt_g_q, cnt_tu_q, tot_b_q, tot_r_q;
	logic [READ_LEN_BITS-1:0] rlen_q, rgc_q;
	logic [SW-1:0] rsum_q;
	logic clamp_q;

	logic [2:0] mode_q;
	logic [7:0] idx_q;
	logic last_q;
	logic [6:0] gcp_q;
	logic [7:0] mq_q;
	logic [79:0] out_q;
	logic kind_q, mvalid_q;

	div_req_t dreq;
	div_rsp_t drsp;

	rbqs_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// Input fields and quality clamp.
	logic [2:0] in_mode;
	logic [7:0] in_b, in_qc, in_idx, in_q;
	logic in_clamp;
	assign in_mode = s_tuser;
	assign in_b = s_tdata[7:0];
	assign in_qc = s_tdata[15:8];
	assign in_idx = s_tdata[23:16];
	assign in_clamp = in_qc < offset_q;
	assign in_q = in_clamp ? 8'd0 : in_qc - offset_q;

	logic [QW-1:0] in_qbin;
	always_comb begin
		if ({1'b0, in_q} >= 9'(QUAL_BINS - 1)) in_qbin = QW'(QUAL_BINS - 1);
		else in_qbin = in_q[QW-1:0];
	end

	assign s_tready = (state_q == ST_IDLE) && !(mvalid_q && !m_tready);
	logic acc;
	assign acc = s_tvalid && s_tready;

	function automatic logic [COUNT_BITS-1:0] sat(input logic [COUNT_BITS-1:0] v);
		return (v == CMAX) ? v : v + 1'b1;
	endfunction

	logic [QW-1:0] mqbin;
	always_comb begin
		if ({1'b0, mq_q} >= 9'(QUAL_BINS - 1)) mqbin = QW'(QUAL_BINS - 1);
		else mqbin = mq_q[QW-1:0];
	end

	always_comb begin
		qaddr = qwa_q;
		gaddr = QW'(gwa_q);
		maddr = mqbin;
		if (state_q == ST_IDLE) begin
			qaddr = (in_mode == MODE_BASE) ? in_qbin : in_idx[QW-1:0];
			gaddr = in_idx[QW-1:0];
			maddr = in_idx[QW-1:0];
		end
		qwe = 1'b0; gwe = 1'b0; mwe = 1'b0;
		qwd = sat(qrd_q); gwd = sat(grd_q); mwd = sat(mrd_q);
		if (state_q == ST_CLEAR) begin
			qwe = 1'b1; gwe = 1'b1; mwe = 1'b1;
			qwd = '0; gwd = '0; mwd = '0;
			qaddr = clr_q; gaddr = clr_q; maddr = clr_q;
		end else if (state_q == ST_BASE) begin
			qwe = 1'b1;
		end else if (state_q == ST_WB_HIST) begin
			gwe = 1'b1; mwe = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (qwe) qmem[qaddr] <= qwd;
		qrd_q <= qmem[qaddr];
		if (gwe && (32'(gaddr) < GC_BINS)) gmem[gaddr[6:0]] <= gwd;
		grd_q <= gmem[gaddr[6:0]];
		if (mwe) mmem[maddr] <= mwd;
		mrd_q <= mmem[maddr];
	end

	assign dreq.start = (state_q == ST_BASE && last_q) || (state_q == ST_DIV_GC && drsp.done);
	assign dreq.num = (state_q == ST_BASE)
		? DIV_BITS'(200) * DIV_BITS'(rgc_q) + DIV_BITS'(rlen_q)
		: DIV_BITS'({rsum_q, 1'b0}) + DIV_BITS'(rlen_q);
	assign dreq.den = DIV_BITS'({rlen_q, 1'b0});

	logic [COUNT_BITS-1:0] tot_val;
	always_comb begin
		unique case (idx_q)
			TOT_A: tot_val = cnt_a_q;
			TOT_C: tot_val = cnt_c_q;
			TOT_G: tot_val = cnt_g_q;
			TOT_TU: tot_val = cnt_tu_q;
			TOT_BASES: tot_val = tot_b_q;
			TOT_READS: tot_val = tot_r_q;
			default: tot_val = '0;
		endcase
	end

	logic [COUNT_BITS-1:0] qv;
	always_comb begin
		qv = '0;
		unique case (mode_q)
			MODE_QBIN: if (32'(idx_q) < QUAL_BINS) qv = qrd_q;
			MODE_GCBIN: if (32'(idx_q) < GC_BINS) qv = grd_q;
			MODE_MQBIN: if (32'(idx_q) < QUAL_BINS) qv = mrd_q;
			MODE_TOTAL: qv = tot_val;
			default: qv = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			offset_q <= 8'd33;
			cnt_a_q <= '0; cnt_c_q <= '0; cnt_g_q <= '0; cnt_tu_q <= '0;
			tot_b_q <= '0; tot_r_q <= '0;
			rlen_q <= '0; rgc_q <= '0; rsum_q <= '0; clamp_q <= 1'b0;
			mvalid_q <= 1'b0;
			out_q <= '0;
			kind_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr == 2'd0) offset_q <= pwdata[7:0];
			if (mvalid_q && m_tready && state_q != ST_OUT) mvalid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == QW'(QUAL_BINS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (acc) begin
					mode_q <= in_mode;
					idx_q <= in_idx;
					last_q <= s_tlast;
					qwa_q <= in_qbin;
					if (in_mode == MODE_BASE) begin
						state_q <= ST_BASE;
						tot_b_q <= sat(tot_b_q);
						priority case (in_b)
							"A", "a": cnt_a_q <= sat(cnt_a_q);
							"G", "g": cnt_g_q <= sat(cnt_g_q);
							"C", "c": cnt_c_q <= sat(cnt_c_q);
							"T", "t", "U", "u": cnt_tu_q <= sat(cnt_tu_q);
							default: ;
						endcase
						if (in_clamp) clamp_q <= 1'b1;
						if (rlen_q != LMAX) begin
							rlen_q <= rlen_q + 1'b1;
							if (in_b == "G" || in_b == "g" || in_b == "C" || in_b == "c")
								rgc_q <= rgc_q + 1'b1;
							rsum_q <= rsum_q + SW'(in_q);
						end
					end else if (in_mode <= MODE_TOTAL) begin
						state_q <= ST_QUERY;
					end
				end
				ST_BASE: state_q <= last_q ? ST_DIV_GC : ST_IDLE;
				ST_QUERY: begin
					out_q <= {1'b0, qv, 39'd0};
					kind_q <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_DIV_GC: if (drsp.done) begin
					gcp_q <= (drsp.quo > 40'd100) ? 7'd100 : drsp.quo[6:0];
					gwa_q <= (drsp.quo > 40'd100) ? 7'd100 : drsp.quo[6:0];
					state_q <= ST_DIV_MQ;
				end
				ST_DIV_MQ: if (drsp.done) begin
					mq_q <= (drsp.quo > 40'd255) ? 8'd255 : drsp.quo[7:0];
					state_q <= ST_RD_HIST;
				end
				ST_RD_HIST: state_q <= ST_WB_HIST;
				ST_WB_HIST: begin
					tot_r_q <= sat(tot_r_q);
					out_q <= {clamp_q, 40'd0, mq_q, gcp_q, rlen_q};
					kind_q <= 1'b0;
					rlen_q <= '0; rgc_q <= '0; rsum_q <= '0; clamp_q <= 1'b0;
					state_q <= ST_OUT;
				end
				// The output register is always empty here: an item is only
				// accepted once the previous result has been taken.
				ST_OUT: begin
					mvalid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata = out_q;
	assign m_tuser = kind_q;
	assign pready = 1'b1;
	assign prdata = {24'd0, offset_q};

endmodule
